[rtl/cms_pkg.sv]
// Package for the complex magnitude sorter: request, result, entry and cell control types, and the control states.
package cms_pkg;

	localparam int CMS_BATCH_SIZE = 8;
	localparam int MAG_W          = 32;
	localparam int SQ_W           = 31;

	typedef struct packed {
		logic signed [15:0] real_part;
		logic signed [15:0] imag_part;
		logic               batch_end;
	} cms_req_t;

	typedef struct packed {
		logic signed [15:0] out_real;
		logic signed [15:0] out_imag;
		logic               out_last;
		logic               overflowed;
	} cms_rsp_t;

	typedef struct packed {
		logic signed [15:0] re;
		logic signed [15:0] im;
	} cms_entry_t;

	typedef struct packed {
		logic insert;
		logic shift;
	} cms_cell_ctl_t;

	typedef enum logic {
		ST_IDLE,
		ST_EMIT
	} cms_state_t;

endpackage

[rtl/cms_cell.sv]
// One cell of the insertion chain: holds one number and its squared magnitude.
module cms_cell import cms_pkg::*; (
	input  logic             clk,
	input  cms_cell_ctl_t    ctl,
	input  logic             occupied,
	input  cms_entry_t       new_ent,
	input  logic [MAG_W-1:0] new_mag,
	input  cms_entry_t       prev_ent,
	input  logic [MAG_W-1:0] prev_mag,
	input  logic             prev_keep,
	input  cms_entry_t       next_ent,
	output cms_entry_t       ent_q,
	output logic [MAG_W-1:0] mag_q,
	output logic             keep
);

	assign keep = occupied && (mag_q >= new_mag);

	always_ff @(posedge clk) begin
		if (ctl.insert && !keep) begin
			if (prev_keep) begin
				ent_q <= new_ent;
				mag_q <= new_mag;
			end else begin
				ent_q <= prev_ent;
				mag_q <= prev_mag;
			end
		end else if (ctl.shift) begin
			ent_q <= next_ent;
		end
	end

endmodule

[rtl/complex_magnitude_sorter_top.sv]
// Top level of the complex magnitude sorter: squaring stage, cell chain and control.
//
// Usage:
//   A request (req) is taken at a rising edge with start high and busy low.
//   Each request carries one complex number; the block squares both parts,
//   then inserts the number into a chain of BATCH_SIZE cells kept ordered by
//   squared magnitude, largest first, equal magnitudes in arrival order.
//   Loading runs at one request per cycle while busy is low; the squaring
//   register lies between each request and its insert.
//   A request with batch_end set raises busy from the next cycle on. The
//   chain then shifts towards cell 0, one number per cycle, and the results
//   appear on rsp with strobe high for one cycle each, the first one taken
//   from cell 0 at the first shift. Busy falls as the last result appears.
//   out_last marks the smallest number; overflowed is set on every result
//   of a batch in which numbers beyond BATCH_SIZE were dropped.
//   After the last result the store is empty and requests are taken again.
//   Results cannot be held off: the receiver must take each strobe.
//   Reset empties the store, clears the overflow flag and drops any request
//   in flight.
module complex_magnitude_sorter_top import cms_pkg::*; #(
	parameter int BATCH_SIZE = CMS_BATCH_SIZE
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  cms_req_t req,
	output cms_rsp_t rsp,
	output logic     strobe
);

	localparam int CNT_W = $clog2(BATCH_SIZE + 1);

	logic             vld_s1;
	cms_req_t         req_s1;
	logic [SQ_W-1:0]  sq_re_s1;
	logic [SQ_W-1:0]  sq_im_s1;
	logic [16:0]      neg_re;
	logic [16:0]      neg_im;
	logic [15:0]      abs_re;
	logic [15:0]      abs_im;
	logic [MAG_W-1:0] new_mag;
	cms_entry_t       new_ent;

	cms_state_t       state_q;
	cms_state_t       state_d;
	logic [CNT_W-1:0] fill_q;
	logic             ovf_q;
	logic             full;
	cms_cell_ctl_t    ctl;
	cms_rsp_t         rsp_q;
	logic             strobe_q;

	cms_entry_t       cell_ent  [BATCH_SIZE];
	logic [MAG_W-1:0] cell_mag  [BATCH_SIZE];
	logic             cell_keep [BATCH_SIZE];

	assign busy = (state_q == ST_EMIT) || (vld_s1 && req_s1.batch_end);

	assign neg_re = -{req.real_part[15], req.real_part};
	assign neg_im = -{req.imag_part[15], req.imag_part};
	assign abs_re = req.real_part[15] ? neg_re[15:0] : req.real_part;
	assign abs_im = req.imag_part[15] ? neg_im[15:0] : req.imag_part;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			req_s1   <= req;
			sq_re_s1 <= SQ_W'(32'(abs_re) * 32'(abs_re));
			sq_im_s1 <= SQ_W'(32'(abs_im) * 32'(abs_im));
		end
	end

	assign new_mag = {1'b0, sq_re_s1} + {1'b0, sq_im_s1};
	assign new_ent = '{re: req_s1.real_part, im: req_s1.imag_part};
	assign full    = (fill_q == CNT_W'(BATCH_SIZE));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (vld_s1 && req_s1.batch_end) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (fill_q == CNT_W'(1)) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctl = '0;
		unique case (state_q)
			ST_IDLE: ctl.insert = vld_s1 && !full;
			ST_EMIT: ctl.shift  = 1'b1;
			default: ctl        = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			fill_q   <= '0;
			ovf_q    <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			strobe_q <= ctl.shift;
			if (ctl.insert) begin
				fill_q <= fill_q + CNT_W'(1);
			end else if (ctl.shift) begin
				fill_q <= fill_q - CNT_W'(1);
			end
			if (vld_s1 && full && state_q == ST_IDLE) begin
				ovf_q <= 1'b1;
			end else if (ctl.shift && fill_q == CNT_W'(1)) begin
				ovf_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			rsp_q.out_real   <= cell_ent[0].re;
			rsp_q.out_imag   <= cell_ent[0].im;
			rsp_q.out_last   <= (fill_q == CNT_W'(1));
			rsp_q.overflowed <= ovf_q;
		end
	end

	assign rsp    = rsp_q;
	assign strobe = strobe_q;

	for (genvar i = 0; i < BATCH_SIZE; i++) begin : g_cell
		cms_entry_t       prev_ent;
		logic [MAG_W-1:0] prev_mag;
		logic             prev_keep;
		cms_entry_t       next_ent;
		logic             occupied;

		if (i == 0) begin : g_head
			assign prev_ent  = new_ent;
			assign prev_mag  = new_mag;
			assign prev_keep = 1'b1;
		end else begin : g_body
			assign prev_ent  = cell_ent[i-1];
			assign prev_mag  = cell_mag[i-1];
			assign prev_keep = cell_keep[i-1];
		end

		if (i == BATCH_SIZE - 1) begin : g_tail
			assign next_ent = cell_ent[i];
		end else begin : g_inner
			assign next_ent = cell_ent[i+1];
		end

		assign occupied = (fill_q > CNT_W'(i));

		cms_cell u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.occupied  (occupied),
			.new_ent   (new_ent),
			.new_mag   (new_mag),
			.prev_ent  (prev_ent),
			.prev_mag  (prev_mag),
			.prev_keep (prev_keep),
			.next_ent  (next_ent),
			.ent_q     (cell_ent[i]),
			.mag_q     (cell_mag[i]),
			.keep      (cell_keep[i])
		);
	end

endmodule

[rtl/cms_checker.sv]
// Port checker for the complex magnitude sorter, bound to the top level.
module cms_checker import cms_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     start,
	input logic     busy,
	input cms_req_t req,
	input cms_rsp_t rsp,
	input logic     strobe
);

	a_end_raises_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && req.batch_end |=> busy)
		else $error("batch end request did not raise busy");

	a_result_in_emit: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(busy))
		else $error("result strobe outside an emission");

	a_results_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !rsp.out_last |=> strobe)
		else $error("gap inside a batch of results");

	a_last_ends_batch: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && rsp.out_last |=> !strobe)
		else $error("result after the last of a batch");

endmodule

bind complex_magnitude_sorter_top cms_checker u_cms_checker (.*);

[tb/sv/complex_magnitude_sorter_top_test.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the complex magnitude sorter: queued requests, batch predictor.
module complex_magnitude_sorter_top_test;
	import cms_pkg::*;

	localparam int STORE_DEPTH  = CMS_BATCH_SIZE;
	localparam int RANDOM_ITEMS = 480;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int TAIL_CYCLES  = 16;

	typedef struct {
		cms_req_t req;
		int       idle_pct;
		bit       drain_first;
	} pending_req_t;

	logic     clk    = 1'b0;
	logic     arst_n = 1'b0;
	logic     start  = 1'b0;
	cms_req_t req    = '0;
	logic     busy;
	cms_rsp_t rsp;
	logic     strobe;

	pending_req_t pending_reqs[$];
	cms_rsp_t     sorted_rsps[$];

	cms_entry_t  sort_entries[STORE_DEPTH];
	logic [31:0] sort_mags[STORE_DEPTH];
	int          sort_fill     = 0;
	bit          sort_overflow = 1'b0;

	int predicted_rsps   = 0;
	int received_rsps    = 0;
	int accepted_reqs    = 0;
	int batches_sent     = 0;
	int overflow_batches = 0;
	int error_count      = 0;
	int cycle_count      = 0;

	complex_magnitude_sorter_top #(
		.BATCH_SIZE(CMS_BATCH_SIZE)
	) uut (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.req   (req),
		.rsp   (rsp),
		.strobe(strobe)
	);

	always #2 clk = ~clk;

	task automatic report_mismatch(input string msg);
		error_count++;
		$display("ERROR at cycle %0d: %s", cycle_count, msg);
	endtask

	task automatic predict_sort(input cms_req_t r);
		logic [31:0] mag;
		int          pos;
		cms_rsp_t    item;
		accepted_reqs++;
		if (sort_fill < STORE_DEPTH) begin
			mag = 32'(longint'(r.real_part) * longint'(r.real_part)
				+ longint'(r.imag_part) * longint'(r.imag_part));
			pos = 0;
			while (pos < sort_fill && sort_mags[pos] >= mag)
				pos++;
			for (int i = sort_fill; i > pos; i--) begin
				sort_entries[i] = sort_entries[i - 1];
				sort_mags[i]    = sort_mags[i - 1];
			end
			sort_entries[pos] = {r.real_part, r.imag_part};
			sort_mags[pos]    = mag;
			sort_fill++;
		end else begin
			sort_overflow = 1'b1;
		end
		if (r.batch_end) begin
			for (int k = 0; k < sort_fill; k++) begin
				item.out_real   = sort_entries[k].re;
				item.out_imag   = sort_entries[k].im;
				item.out_last   = (k == sort_fill - 1);
				item.overflowed = sort_overflow;
				sorted_rsps.push_back(item);
			end
			predicted_rsps += sort_fill;
			batches_sent++;
			if (sort_overflow)
				overflow_batches++;
			sort_fill     = 0;
			sort_overflow = 1'b0;
		end
	endtask

	task automatic queue_req(input logic signed [15:0] re, input logic signed [15:0] im,
			input bit last, input int idle_pct, input bit drain_first);
		pending_req_t p;
		p.req.real_part = re;
		p.req.imag_part = im;
		p.req.batch_end = last;
		p.idle_pct      = idle_pct;
		p.drain_first   = drain_first;
		pending_reqs.push_back(p);
	endtask

	function automatic logic signed [15:0] rand_part(input int mode);
		logic signed [15:0] v;
		case (mode)
			1: v = 16'($signed($urandom_range(8)) - 4);
			2: begin
				case ($urandom_range(5))
					0: v = -16'sd32768;
					1: v = 16'sd32767;
					2: v = 16'sd0;
					3: v = -16'sd1;
					4: v = 16'sd1;
					default: v = -16'sd32767;
				endcase
			end
			default: v = 16'($urandom());
		endcase
		return v;
	endfunction

	always @(posedge clk) begin : drive_reqs
		pending_req_t next_item;
		if (arst_n) begin
			if (start && !busy)
				predict_sort(req);
			if (start && busy) begin
				// hold the request until taken
			end else if (pending_reqs.size() != 0
					&& !(pending_reqs[0].drain_first
						&& (predicted_rsps != received_rsps || busy))
					&& $urandom_range(99) >= pending_reqs[0].idle_pct) begin
				next_item = pending_reqs.pop_front();
				start <= 1'b1;
				req   <= next_item.req;
			end else begin
				start <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : check_rsps
		cms_rsp_t want;
		if (arst_n && strobe) begin
			if (sorted_rsps.size() == 0) begin
				report_mismatch($sformatf("unexpected result re=%0d im=%0d last=%0b ovf=%0b",
					rsp.out_real, rsp.out_imag, rsp.out_last, rsp.overflowed));
			end else begin
				want = sorted_rsps.pop_front();
				if (rsp.out_real !== want.out_real)
					report_mismatch($sformatf("out_real %0d, expected %0d",
						rsp.out_real, want.out_real));
				if (rsp.out_imag !== want.out_imag)
					report_mismatch($sformatf("out_imag %0d, expected %0d",
						rsp.out_imag, want.out_imag));
				if (rsp.out_last !== want.out_last)
					report_mismatch($sformatf("out_last %0b, expected %0b",
						rsp.out_last, want.out_last));
				if (rsp.overflowed !== want.overflowed)
					report_mismatch($sformatf("overflowed %0b, expected %0b",
						rsp.overflowed, want.overflowed));
				received_rsps <= received_rsps + 1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d results outstanding",
				cycle_count, sorted_rsps.size());
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		int random_count;
		int phase;
		int last_phase;
		int idle;
		int batch_len;
		int mode;
		random_count = 0;
		last_phase   = -1;

		// extremes of both parts
		queue_req(-16'sd32768, -16'sd32768, 1'b0, 0, 1'b0);
		queue_req(16'sd32767, 16'sd32767, 1'b0, 0, 1'b0);
		queue_req(16'sd0, 16'sd0, 1'b0, 0, 1'b0);
		queue_req(-16'sd1, 16'sd1, 1'b1, 0, 1'b0);
		// equal magnitudes keep arrival order
		queue_req(16'sd3, 16'sd4, 1'b0, 0, 1'b0);
		queue_req(-16'sd4, 16'sd3, 1'b0, 0, 1'b0);
		queue_req(16'sd0, -16'sd5, 1'b1, 0, 1'b0);
		// single-number batch
		queue_req(-16'sd32768, 16'sd0, 1'b1, 0, 1'b0);
		// store filled exactly
		queue_req(16'sd32767, -16'sd32768, 1'b0, 0, 1'b0);
		queue_req(16'sd100, 16'sd0, 1'b0, 0, 1'b0);
		queue_req(-16'sd32768, 16'sd32767, 1'b0, 0, 1'b0);
		queue_req(16'sd0, 16'sd32767, 1'b0, 0, 1'b0);
		queue_req(16'sd1, 16'sd0, 1'b0, 0, 1'b0);
		queue_req(16'sd5000, -16'sd5000, 1'b0, 0, 1'b0);
		queue_req(16'sd0, 16'sd0, 1'b0, 0, 1'b0);
		queue_req(-16'sd100, 16'sd0, 1'b1, 0, 1'b0);
		// full store drops the rest, batch end included
		for (int n = 0; n < STORE_DEPTH + 1; n++)
			queue_req(16'(n * 1000 - 4000), 16'(-n * 7), n == STORE_DEPTH, 0, 1'b0);

		while (random_count < RANDOM_ITEMS) begin
			phase = random_count * 3 / RANDOM_ITEMS;
			idle  = (phase == 0) ? 0 : (phase == 1) ? 87 : 14;
			if ($urandom_range(3) == 0)
				idle = 0;
			if ($urandom_range(5) == 0)
				batch_len = $urandom_range(STORE_DEPTH + 4, STORE_DEPTH + 1);
			else
				batch_len = $urandom_range(STORE_DEPTH, 1);
			mode = ($urandom_range(3) == 0) ? $urandom_range(2, 1) : 0;
			for (int n = 0; n < batch_len; n++) begin
				queue_req(rand_part(mode), rand_part(mode), n == batch_len - 1, idle,
					phase != last_phase && n == 0);
				random_count++;
			end
			last_phase = phase;
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		do
			@(negedge clk);
		while (pending_reqs.size() != 0 || start || received_rsps != predicted_rsps);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sorted_rsps.size() != 0)
			report_mismatch($sformatf("%0d expected results never arrived",
				sorted_rsps.size()));

		$display("Checked %0d results from %0d requests in %0d batches, %0d of them overflowing.",
			received_rsps, accepted_reqs, batches_sent, overflow_batches);
		$display("Sender gaps ran at none, 87 and 14 in a hundred, with drain pauses between.");
		if (error_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("%0d mismatches", error_count);
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
